>>> rtl/protected_region_table_macros.svh
// assertion macros shared by the region table rtl
`ifndef PROTECTED_REGION_TABLE_MACROS_SVH
`define PROTECTED_REGION_TABLE_MACROS_SVH

// checked only while out of reset
`define PRT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define PRT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/prt_pkg.sv
// types and codes of the protected region table
`default_nettype none

package prt_pkg;

    typedef enum logic [1:0] {
        OP_REGISTER  = 2'd0,
        OP_UNPROTECT = 2'd1,
        OP_REPROTECT = 2'd2,
        OP_REMOVE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOMATCH = 2'd2
    } status_t;

    localparam int SLOT_W  = 7;
    localparam int USED_W  = 8;
    localparam int FIELD_W = 48;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [USED_W-1:0]  used_t;
    typedef logic [FIELD_W-1:0] field_t;

    // result of comparing the probe against one stored region
    typedef struct packed {
        logic covers;
        logic exact;
    } match_t;

endpackage

`default_nettype wire

>>> rtl/prt_match.sv
// range and exact-base compare unit shared by all table scans
`default_nettype none

module prt_match #(
    parameter int ADDR_BITS = 48
) (
    input  wire logic [ADDR_BITS-1:0] probe,
    input  wire logic [ADDR_BITS-1:0] base,
    input  wire logic [ADDR_BITS-1:0] len,
    output prt_pkg::match_t           result
);

    logic [ADDR_BITS:0] diff;

    // top bit of the difference is the borrow, set when probe is below base
    assign diff = {1'b0, probe} - {1'b0, base};

    always_comb
    begin
        result.covers = !diff[ADDR_BITS] && (diff[ADDR_BITS-1:0] < len);
        result.exact  = (probe == base);
    end

endmodule

`default_nettype wire

>>> rtl/protected_region_table.sv
// Protected region table: an ordered table of up to REGION_SLOTS regions (base, size,
// protected flag) held in one single-port-read, single-port-write memory. An item is
// taken when start is high and busy is low; busy then stays high until the result,
// which appears for one cycle with done high and must be taken in that cycle.
// Unprotect and reprotect scan the table through one shared compare unit, one entry per
// cycle. Remove scans the same way, then moves every later entry down one slot, one
// entry per cycle through the memory port. A new item may be started in the cycle that
// done is high.
`default_nettype none
`include "protected_region_table_macros.svh"

module protected_region_table #(
    parameter int REGION_SLOTS = 128,
    parameter int ADDR_BITS    = 48
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [1:0]           operation,
    input  wire logic [ADDR_BITS-1:0] address,
    input  wire logic [ADDR_BITS-1:0] region_length,
    output logic                      busy,
    output logic                      done,
    output logic [1:0]                status,
    output logic [6:0]                slot,
    output logic [47:0]               region_base,
    output logic [47:0]               region_bytes,
    output logic                      access_open,
    output logic [7:0]                entries_used
);

    localparam int IDX_W = $clog2(REGION_SLOTS);
    localparam int CNT_W = $clog2(REGION_SLOTS + 1);
    localparam int ENT_W = 2 * ADDR_BITS + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REG,
        S_SCAN,
        S_SHIFT
    } state_t;

    state_t                 state_reg;
    prt_pkg::op_t           op_reg;
    logic [ADDR_BITS-1:0]   addr_reg;
    logic [ADDR_BITS-1:0]   len_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       scan_idx_reg;
    logic [IDX_W-1:0]       cmp_idx_reg;
    logic                   cmp_valid_reg;
    logic                   wr_pend_reg;

    logic                   done_reg;
    prt_pkg::status_t       status_reg;
    prt_pkg::slot_t         slot_reg;
    prt_pkg::field_t        base_out_reg;
    prt_pkg::field_t        bytes_out_reg;
    logic                   open_reg;
    prt_pkg::used_t         used_reg;

    // region memory: {flag, length, base}
    logic [ENT_W-1:0]       mem [REGION_SLOTS];
    logic [ENT_W-1:0]       rd_data_reg;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [ENT_W-1:0]       wr_data;

    logic [ADDR_BITS-1:0]   rd_base;
    logic [ADDR_BITS-1:0]   rd_len;
    prt_pkg::match_t        cmp;
    logic                   hit;
    logic                   more;
    logic                   full;

    assign rd_base = rd_data_reg[ADDR_BITS-1:0];
    assign rd_len  = rd_data_reg[2*ADDR_BITS-1:ADDR_BITS];

    prt_match #(
        .ADDR_BITS (ADDR_BITS)
    ) u_match (
        .probe  (addr_reg),
        .base   (rd_base),
        .len    (rd_len),
        .result (cmp)
    );

    assign hit  = cmp_valid_reg &&
                  ((op_reg == prt_pkg::OP_REMOVE) ? cmp.exact : cmp.covers);
    assign more = (scan_idx_reg < count_reg);
    assign full = (count_reg == CNT_W'(REGION_SLOTS));

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = scan_idx_reg[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = cmp_idx_reg;
        wr_data = rd_data_reg;
        case (state_reg)
            S_REG:
            begin
                wr_en   = !full;
                wr_addr = count_reg[IDX_W-1:0];
                wr_data = {1'b1, len_reg, addr_reg};
            end
            S_SCAN:
            begin
                rd_en = !hit && more;
                if (hit && (op_reg != prt_pkg::OP_REMOVE))
                begin
                    wr_en   = 1'b1;
                    wr_data = {(op_reg == prt_pkg::OP_REPROTECT), rd_len, rd_base};
                end
            end
            S_SHIFT:
            begin
                // read the next entry while the one read before lands a slot lower
                rd_en = more;
                wr_en = wr_pend_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        op_reg        <= prt_pkg::op_t'(operation);
                        addr_reg      <= address;
                        len_reg       <= region_length;
                        scan_idx_reg  <= '0;
                        cmp_valid_reg <= 1'b0;
                        wr_pend_reg   <= 1'b0;
                        if (prt_pkg::op_t'(operation) == prt_pkg::OP_REGISTER)
                        begin
                            state_reg <= S_REG;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_REG:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                    if (full)
                    begin
                        status_reg    <= prt_pkg::ST_FULL;
                        slot_reg      <= '0;
                        base_out_reg  <= '0;
                        bytes_out_reg <= '0;
                        open_reg      <= 1'b0;
                        used_reg      <= prt_pkg::used_t'(count_reg);
                    end
                    else
                    begin
                        count_reg     <= count_reg + CNT_W'(1);
                        status_reg    <= prt_pkg::ST_DONE;
                        slot_reg      <= prt_pkg::slot_t'(count_reg);
                        base_out_reg  <= prt_pkg::field_t'(addr_reg);
                        bytes_out_reg <= prt_pkg::field_t'(len_reg);
                        open_reg      <= 1'b0;
                        used_reg      <= prt_pkg::used_t'(count_reg + CNT_W'(1));
                    end
                end
                S_SCAN:
                begin
                    if (hit)
                    begin
                        status_reg    <= prt_pkg::ST_DONE;
                        slot_reg      <= prt_pkg::slot_t'(cmp_idx_reg);
                        base_out_reg  <= prt_pkg::field_t'(rd_base);
                        bytes_out_reg <= prt_pkg::field_t'(rd_len);
                        open_reg      <= (op_reg != prt_pkg::OP_REPROTECT);
                        cmp_valid_reg <= 1'b0;
                        if (op_reg == prt_pkg::OP_REMOVE)
                        begin
                            scan_idx_reg <= CNT_W'(cmp_idx_reg) + CNT_W'(1);
                            wr_pend_reg  <= 1'b0;
                            state_reg    <= S_SHIFT;
                        end
                        else
                        begin
                            used_reg  <= prt_pkg::used_t'(count_reg);
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (more)
                    begin
                        scan_idx_reg  <= scan_idx_reg + CNT_W'(1);
                        cmp_idx_reg   <= scan_idx_reg[IDX_W-1:0];
                        cmp_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        status_reg    <= prt_pkg::ST_NOMATCH;
                        slot_reg      <= '0;
                        base_out_reg  <= '0;
                        bytes_out_reg <= '0;
                        open_reg      <= 1'b0;
                        used_reg      <= prt_pkg::used_t'(count_reg);
                        cmp_valid_reg <= 1'b0;
                        done_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_SHIFT:
                begin
                    if (more)
                    begin
                        scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                        cmp_idx_reg  <= IDX_W'(scan_idx_reg - CNT_W'(1));
                        wr_pend_reg  <= 1'b1;
                    end
                    else
                    begin
                        wr_pend_reg <= 1'b0;
                        if (!wr_pend_reg)
                        begin
                            count_reg <= count_reg - CNT_W'(1);
                            used_reg  <= prt_pkg::used_t'(count_reg - CNT_W'(1));
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign slot         = slot_reg;
    assign region_base  = base_out_reg;
    assign region_bytes = bytes_out_reg;
    assign access_open  = open_reg;
    assign entries_used = used_reg;

    `PRT_ASSERT(a_done_after_busy, done |-> $past(state_reg != S_IDLE),
        "result without a busy cycle")
    `PRT_ASSERT(a_count_bound, count_reg <= CNT_W'(REGION_SLOTS), "region count overflow")
    `PRT_ASSERT_ALWAYS(a_idle_after_reset, !rst_n |=> !busy, "busy right after reset")
    `PRT_ASSERT(a_full_only_register,
        (done && (status_reg == prt_pkg::ST_FULL)) |-> (op_reg == prt_pkg::OP_REGISTER),
        "full status on a non-register item")
    `PRT_ASSERT(a_miss_clears_fields,
        (done && (status_reg != prt_pkg::ST_DONE)) |-> ((slot_reg == '0) && !open_reg),
        "miss result carries slot or access")
    `PRT_ASSERT(a_scan_write_on_hit,
        (wr_en && (state_reg == S_SCAN)) |-> hit, "table write during scan without a hit")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// self-checking testbench for the protected region table
`timescale 1ns / 1ps

module tb_top;

    localparam int TABLE_SLOTS  = 128;
    localparam int RANDOM_ITEMS = 1730;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 300;

    typedef struct {
        prt_pkg::op_t    op;
        prt_pkg::field_t addr;
        prt_pkg::field_t len;
    } region_cmd_t;

    typedef struct {
        prt_pkg::status_t status;
        prt_pkg::slot_t   slot;
        prt_pkg::field_t  base;
        prt_pkg::field_t  bytes;
        logic             open;
        prt_pkg::used_t   used;
    } region_reply_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    logic [1:0]      operation = '0;
    prt_pkg::field_t address = '0;
    prt_pkg::field_t region_length = '0;
    logic            busy;
    logic            done;
    logic [1:0]      status;
    logic [6:0]      slot;
    logic [47:0]     region_base;
    logic [47:0]     region_bytes;
    logic            access_open;
    logic [7:0]      entries_used;

    region_cmd_t   region_cmds[$];
    region_reply_t expected_replies[$];

    // predicted table contents
    prt_pkg::field_t tbl_base[TABLE_SLOTS];
    prt_pkg::field_t tbl_size[TABLE_SLOTS];
    bit              tbl_locked[TABLE_SLOTS];
    int              tbl_count = 0;

    // table contents as seen while planning the stimulus
    prt_pkg::field_t plan_bases[$];
    prt_pkg::field_t plan_sizes[$];

    int accepted_n = 0;
    int mismatch_count = 0;
    int stall_cycles = 0;

    protected_region_table #(
        .REGION_SLOTS (TABLE_SLOTS),
        .ADDR_BITS    (48)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .operation     (operation),
        .address       (address),
        .region_length (region_length),
        .busy          (busy),
        .done          (done),
        .status        (status),
        .slot          (slot),
        .region_base   (region_base),
        .region_bytes  (region_bytes),
        .access_open   (access_open),
        .entries_used  (entries_used)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic prt_pkg::field_t rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    function automatic void queue_cmd(prt_pkg::op_t op, prt_pkg::field_t a,
                                      prt_pkg::field_t l);
        region_cmd_t c;
        int hit;
        c.op = op;
        c.addr = a;
        c.len = l;
        hit = -1;
        region_cmds.push_back(c);
        if (op == prt_pkg::OP_REGISTER && plan_bases.size() < TABLE_SLOTS)
        begin
            plan_bases.push_back(a);
            plan_sizes.push_back(l);
        end
        else if (op == prt_pkg::OP_REMOVE)
        begin
            for (int j = 0; j < plan_bases.size(); j++)
                if (hit < 0 && plan_bases[j] == a)
                    hit = j;
            if (hit >= 0)
            begin
                plan_bases.delete(hit);
                plan_sizes.delete(hit);
            end
        end
    endfunction

    // updates the predicted table and works out the reply to one item
    function automatic void apply_region_op(input prt_pkg::op_t op,
                                            input prt_pkg::field_t addr,
                                            input prt_pkg::field_t len,
                                            output region_reply_t r);
        int hit;
        hit = -1;
        r.status = prt_pkg::ST_NOMATCH;
        r.slot = '0;
        r.base = '0;
        r.bytes = '0;
        r.open = 1'b0;
        case (op)
            prt_pkg::OP_REGISTER:
            begin
                if (tbl_count >= TABLE_SLOTS)
                    r.status = prt_pkg::ST_FULL;
                else
                begin
                    tbl_base[tbl_count] = addr;
                    tbl_size[tbl_count] = len;
                    tbl_locked[tbl_count] = 1'b1;
                    r.status = prt_pkg::ST_DONE;
                    r.slot = prt_pkg::slot_t'(tbl_count);
                    r.base = addr;
                    r.bytes = len;
                    tbl_count++;
                end
            end
            prt_pkg::OP_UNPROTECT, prt_pkg::OP_REPROTECT:
            begin
                // range end is one bit wider, so compare the offset instead
                for (int j = 0; j < tbl_count; j++)
                    if (hit < 0 && addr >= tbl_base[j] &&
                        (addr - tbl_base[j]) < tbl_size[j])
                        hit = j;
                if (hit >= 0)
                begin
                    tbl_locked[hit] = (op == prt_pkg::OP_REPROTECT);
                    r.status = prt_pkg::ST_DONE;
                    r.slot = prt_pkg::slot_t'(hit);
                    r.base = tbl_base[hit];
                    r.bytes = tbl_size[hit];
                    r.open = (op == prt_pkg::OP_UNPROTECT);
                end
            end
            default:
            begin
                for (int j = 0; j < tbl_count; j++)
                    if (hit < 0 && tbl_base[j] == addr)
                        hit = j;
                if (hit >= 0)
                begin
                    r.status = prt_pkg::ST_DONE;
                    r.slot = prt_pkg::slot_t'(hit);
                    r.base = tbl_base[hit];
                    r.bytes = tbl_size[hit];
                    r.open = 1'b1;
                    for (int j = hit; j + 1 < tbl_count; j++)
                    begin
                        tbl_base[j] = tbl_base[j + 1];
                        tbl_size[j] = tbl_size[j + 1];
                        tbl_locked[j] = tbl_locked[j + 1];
                    end
                    tbl_count--;
                end
            end
        endcase
        r.used = prt_pkg::used_t'(tbl_count);
    endfunction

    // driver: presents the oldest pending item, with start dropped at random
    always @(negedge clk)
    begin : drive_blk
        bit hold_off;
        hold_off = (accepted_n >= 700 && accepted_n < 1000) ? 1'b0
                   : ($urandom_range(0, 99) < 13);
        if (!rst_n || region_cmds.size() == 0 || hold_off)
            start <= 1'b0;
        else
        begin
            start <= 1'b1;
            operation <= region_cmds[0].op;
            address <= region_cmds[0].addr;
            region_length <= region_cmds[0].len;
        end
    end

    // monitor: checks each result, then predicts for an item taken at this edge
    always @(posedge clk)
    begin : watch_blk
        region_reply_t want;
        region_reply_t got;
        if (rst_n)
        begin
            if (done)
            begin
                got.status = prt_pkg::status_t'(status);
                got.slot = slot;
                got.base = region_base;
                got.bytes = region_bytes;
                got.open = access_open;
                got.used = entries_used;
                if (expected_replies.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"unexpected result: st=%0d slot=%0d base=%h bytes=%h",
                                  " open=%0d used=%0d"},
                                 got.status, got.slot, got.base, got.bytes,
                                 got.open, got.used);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (got.status !== want.status || got.slot !== want.slot ||
                        got.base !== want.base || got.bytes !== want.bytes ||
                        got.open !== want.open || got.used !== want.used)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display({"mismatch: exp st=%0d slot=%0d base=%h bytes=%h",
                                      " open=%0d used=%0d"},
                                     want.status, want.slot, want.base, want.bytes,
                                     want.open, want.used);
                            $display({"          got st=%0d slot=%0d base=%h bytes=%h",
                                      " open=%0d used=%0d"},
                                     got.status, got.slot, got.base, got.bytes,
                                     got.open, got.used);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                apply_region_op(prt_pkg::op_t'(operation), address, region_length, want);
                expected_replies.push_back(want);
                void'(region_cmds.pop_front());
                accepted_n++;
            end
        end
    end

    // watchdog on cycles where neither an item nor a result moves
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial
    begin
        prt_pkg::field_t a;
        prt_pkg::field_t l;
        logic [63:0]     wide;
        int              r;
        int              idx;
        prt_pkg::op_t    op;
        bit              fill;

        // empty table, zero-size region, range ending at the top of the address space
        queue_cmd(prt_pkg::OP_UNPROTECT, '0, '0);
        queue_cmd(prt_pkg::OP_REMOVE, '1, '1);
        queue_cmd(prt_pkg::OP_REGISTER, '0, '0);
        queue_cmd(prt_pkg::OP_UNPROTECT, '0, '1);
        queue_cmd(prt_pkg::OP_REGISTER, '0, 48'd1);
        queue_cmd(prt_pkg::OP_UNPROTECT, '0, '0);
        queue_cmd(prt_pkg::OP_REGISTER, '1, '1);
        queue_cmd(prt_pkg::OP_UNPROTECT, '1, '0);
        queue_cmd(prt_pkg::OP_REGISTER, 48'h1000, '1);
        // overlapping regions: lowest slot wins
        queue_cmd(prt_pkg::OP_REPROTECT, '1, '0);
        queue_cmd(prt_pkg::OP_REGISTER, 48'h1000, 48'h10);
        queue_cmd(prt_pkg::OP_UNPROTECT, 48'h100f, '0);
        queue_cmd(prt_pkg::OP_REMOVE, 48'h1000, '0);
        queue_cmd(prt_pkg::OP_UNPROTECT, 48'h100f, '0);
        queue_cmd(prt_pkg::OP_REPROTECT, 48'h1010, '0);
        // zero-size region still removable by base
        queue_cmd(prt_pkg::OP_REMOVE, '0, '0);
        queue_cmd(prt_pkg::OP_REMOVE, 48'h5555_5555_5555, '0);
        queue_cmd(prt_pkg::OP_REPROTECT, 48'd1, '0);
        queue_cmd(prt_pkg::OP_UNPROTECT, 48'haaaa_aaaa_aaaa, 48'h5555_5555_5555);
        queue_cmd(prt_pkg::OP_REMOVE, '1, '0);
        queue_cmd(prt_pkg::OP_REMOVE, '0, '0);

        // alternate filling (reaches a full table) and draining phases
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            fill = ((n / 300) % 2) == 0;
            r = $urandom_range(0, 99);
            if (r < (fill ? 65 : 15))
                op = prt_pkg::OP_REGISTER;
            else if (r < (fill ? 75 : 65))
                op = prt_pkg::OP_REMOVE;
            else if (r < (fill ? 87 : 82))
                op = prt_pkg::OP_UNPROTECT;
            else
                op = prt_pkg::OP_REPROTECT;
            a = rand48();
            l = rand48();
            idx = (plan_bases.size() == 0) ? 0 : $urandom_range(0, plan_bases.size() - 1);
            r = $urandom_range(0, 99);
            case (op)
                prt_pkg::OP_REGISTER:
                begin
                    if (r < 15 && plan_bases.size() != 0)
                        a = plan_bases[idx];
                    else if (r < 25)
                        a = {28'($urandom_range(0, 255)), 20'h0};
                    case ($urandom_range(0, 7))
                        0: l = '0;
                        1: l = 48'd1;
                        2, 3: l = 48'($urandom_range(1, 4096));
                        4: l = '1;
                        5: l = rand48() >> $urandom_range(0, 47);
                        default: ;
                    endcase
                end
                prt_pkg::OP_REMOVE:
                begin
                    if (r < 75 && plan_bases.size() != 0)
                        a = plan_bases[idx];
                end
                default:
                begin
                    if (plan_bases.size() != 0 && r < 85)
                    begin
                        if (r < 60)
                        begin
                            wide = {$urandom, $urandom};
                            if (plan_sizes[idx] != 0)
                                a = plan_bases[idx] +
                                    prt_pkg::field_t'(wide % plan_sizes[idx]);
                            else
                                a = plan_bases[idx];
                        end
                        else if (r < 68)
                            a = plan_bases[idx] + plan_sizes[idx] - 48'd1;
                        else if (r < 78)
                            a = plan_bases[idx] + plan_sizes[idx];
                        else
                            a = plan_bases[idx] - 48'd1;
                    end
                end
            endcase
            queue_cmd(op, a, l);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (region_cmds.size() != 0 || expected_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/prt_pkg.sv
rtl/prt_match.sv
rtl/protected_region_table.sv
tb/tb_top.sv
